// ===== rtl/hcbp_pkg.sv =====
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  localparam int SYM_W        = 8;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int BYTE_W       = 8;
  localparam int LAST_BIT_POS = 7;

  // Depth of the command and result queues, and the widths that follow from it
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_word_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic             empty;
    logic [CNT_W-1:0] space;
  } q_stat_t;

endpackage

// ===== rtl/hcbp_fifo.sv =====
// Small queue with two write lanes and one read port.
module hcbp_fifo import hcbp_pkg::*; #(
  parameter type entry_t = logic [7:0]
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   wr_valid_i,
  input  entry_t [1:0] wr_data_i,
  input  logic         rd_i,
  output entry_t       rd_data_o,
  output q_stat_t      stat_o
);

  entry_t [QUEUE_DEPTH-1:0] mem_q;
  logic [PTR_W-1:0]         wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         n_wr;
  logic [PTR_W-1:0]         wptr_nxt;

  assign n_wr     = CNT_W'(wr_valid_i[0]) + CNT_W'(wr_valid_i[1]);
  assign wptr_nxt = wptr_q + PTR_W'(1);
  assign wptr_d   = wptr_q + PTR_W'(n_wr);
  assign rptr_d   = rptr_q + PTR_W'(rd_i);
  assign count_d  = count_q + n_wr - CNT_W'(rd_i);

  assign rd_data_o    = mem_q[rptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.space = CNT_W'(QUEUE_DEPTH) - count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i[0]) begin
      mem_q[wptr_q] <= wr_data_i[0];
    end
    if (wr_valid_i[1]) begin
      mem_q[wptr_nxt] <= wr_data_i[1];
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_wr <= stat_o.space)
    else $error("queue written beyond its free space");

  a_lane_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i[1] |-> wr_valid_i[0])
    else $error("second write lane used without the first");

endmodule

// ===== rtl/hcbp_front.sv =====
// Front end: takes items, keeps the code table and classifies work for the packer.
module hcbp_front import hcbp_pkg::*; #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t in_word_i,
  output logic     full_o,
  input  q_stat_t  cmd_stat_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_LIM_L = LEN_W'(LEN_LIM);

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_vld_q;

  logic              stg_vld_q, stg_vld_d;
  cmd_kind_e         stg_kind_q;
  logic [CODE_W-1:0] code_rd_q;
  logic [LEN_W-1:0]  len_rd_q;
  logic              lvld_rd_q;

  logic             accept, in_range, is_load, is_cmd;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] ld_len, len_eff;
  logic             stg_drop, stg_go;

  assign idx      = in_word_i.symbol[IDX_W-1:0];
  assign in_range = ({1'b0, in_word_i.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign ld_len   = (in_word_i.code_length > LEN_LIM_L) ? LEN_LIM_L : in_word_i.code_length;

  always_comb begin
    is_load = 1'b0;
    is_cmd  = 1'b0;
    case (in_word_i.operation)
      OP_LOAD:   is_load = in_range;
      OP_ENCODE: is_cmd  = in_range;
      OP_FLUSH:  is_cmd  = 1'b1;
      default:   is_cmd  = 1'b0;
    endcase
  end

  // An absent symbol leaves the stage without taking a queue slot
  assign len_eff  = lvld_rd_q ? len_rd_q : '0;
  assign stg_drop = (stg_kind_q == CMD_ENCODE) && (len_eff == '0);
  assign stg_go   = stg_vld_q && (stg_drop || (cmd_stat_i.space != '0));
  assign full_o   = stg_vld_q && !stg_go;
  assign accept   = push_i && !full_o;

  assign cmd_push_o = stg_vld_q && !stg_drop && (cmd_stat_i.space != '0);
  assign cmd_o      = '{kind: stg_kind_q, code: code_rd_q, len: len_eff};

  assign stg_vld_d = accept ? is_cmd : (stg_go ? 1'b0 : stg_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      len_vld_q <= '0;
    end else begin
      stg_vld_q <= stg_vld_d;
      if (accept && is_load) begin
        len_vld_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (is_load) begin
        code_mem[idx] <= in_word_i.code_word;
        len_mem[idx]  <= ld_len;
      end
      code_rd_q  <= code_mem[idx];
      len_rd_q   <= len_mem[idx];
      lvld_rd_q  <= len_vld_q[idx];
      stg_kind_q <= (in_word_i.operation == OP_FLUSH) ? CMD_FLUSH : CMD_ENCODE;
    end
  end

endmodule

// ===== rtl/hcbp_packer.sv =====
// Back end: appends code bits to the pending byte and emits completed bytes.
module hcbp_packer import hcbp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_stat_t         cmd_stat_i,
  input  cmd_t            cmd_i,
  output logic            cmd_pop_o,
  input  q_stat_t         out_stat_i,
  output logic [1:0]      out_push_o,
  output out_word_t [1:0] out_data_o
);

  localparam int ACC_W = BYTE_W + CODE_W;

  logic [BYTE_W-1:0] pend_q, pend_d;
  logic [2:0]        cnt_q, cnt_d;

  logic              take;
  logic [CODE_W-1:0] rev, rev_m;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [1:0]        n_bytes;

  function automatic logic [CODE_W-1:0] bit_rev(input logic [CODE_W-1:0] w);
    logic [CODE_W-1:0] r;
    for (int i = 0; i < CODE_W; i++) begin
      r[CODE_W-1-i] = w[i];
    end
    return r;
  endfunction

  assign take      = !cmd_stat_i.empty && (out_stat_i.space >= CNT_W'(2));
  assign cmd_pop_o = take;

  // First code bit lands just below the bits already pending
  assign rev     = bit_rev(cmd_i.code);
  assign rev_m   = rev & ~({CODE_W{1'b1}} >> cmd_i.len);
  assign acc     = {pend_q, {CODE_W{1'b0}}} | ({rev_m, {BYTE_W{1'b0}}} >> cnt_q);
  assign total   = LEN_W'(cnt_q) + cmd_i.len;
  assign n_bytes = total[LEN_W-1:3];

  always_comb begin
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    out_push_o = 2'b00;
    out_data_o[0] = '{out_byte: acc[ACC_W-1 -: BYTE_W], last_of_run: (n_bytes == 2'd1)};
    out_data_o[1] = '{out_byte: acc[ACC_W-BYTE_W-1 -: BYTE_W], last_of_run: 1'b1};
    if (take) begin
      case (cmd_i.kind)
        CMD_FLUSH: begin
          out_push_o    = 2'b01;
          out_data_o[0] = '{out_byte: pend_q, last_of_run: 1'b1};
          pend_d        = '0;
          cnt_d         = '0;
        end
        CMD_ENCODE: begin
          cnt_d = total[2:0];
          case (n_bytes)
            2'd0: begin
              pend_d = acc[ACC_W-1 -: BYTE_W];
            end
            2'd1: begin
              out_push_o = 2'b01;
              pend_d     = acc[ACC_W-BYTE_W-1 -: BYTE_W];
            end
            default: begin
              out_push_o = 2'b11;
              pend_d     = acc[BYTE_W-1:0];
            end
          endcase
        end
        default: begin
          pend_d = pend_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i.kind == CMD_FLUSH) |=> (cnt_q == '0 && pend_q == '0))
    else $error("pending byte not cleared after flush");

  a_unused_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & ~({BYTE_W{1'b1}} << (3'(LAST_BIT_POS) - cnt_q + 3'd1))) == '0 || cnt_q == '0)
    else $error("pending byte holds bits below its fill level");

endmodule

// ===== rtl/huffman_code_bit_packer_top.sv =====
// Top level of the Huffman code bit packer: front end, command queue, packer, result queue.
//
// The block keeps a table of Huffman codes and packs code bits into bytes, first bit in the
// most significant position. A load word writes one table entry (lengths above the limit are
// cut to it), an encode word appends the code of its symbol and may complete up to two bytes,
// and a flush word emits the pending byte left-aligned, even when it holds no bits. The table
// sits in the front end, which reads it as a word is taken and hands encode and
// flush work to the packer through a four-entry command queue; loads, absent symbols and
// unused operation codes end there. The packer does one command a cycle once its result queue
// has two free slots. Sustained rate is one input word per cycle as long as results are popped
// as fast as they appear; a symbol that completes two bytes needs two pops, so the pop side sets
// the long-run figure. A result passes through the front-end stage register, the command
// queue and the result queue before it shows on the result ports, and can then be popped.
// The length table comes out of reset cleared, so no preparation time is needed after reset.
module huffman_code_bit_packer_top import hcbp_pkg::*; #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // Input side
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  // Result side
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  q_stat_t          cmd_stat, out_stat;
  logic             cmd_push, cmd_pop;
  cmd_t             cmd_in, cmd_out;
  logic [1:0]       out_push;
  out_word_t [1:0]  out_data;
  cmd_t [1:0]       cmd_lanes;

  // Accept words, keep the table, and sort out what needs the packer
  hcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .full_o     (full),
    .cmd_stat_i (cmd_stat),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Command queue: one write lane used, second lane held idle
  assign cmd_lanes[0] = cmd_in;
  assign cmd_lanes[1] = cmd_in;

  hcbp_fifo #(
    .entry_t (cmd_t)
  ) u_cmd_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i ({1'b0, cmd_push}),
    .wr_data_i  (cmd_lanes),
    .rd_i       (cmd_pop),
    .rd_data_o  (cmd_out),
    .stat_o     (cmd_stat)
  );

  // Pack bits; advance only with room for two result words
  hcbp_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_stat_i (cmd_stat),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .out_stat_i (out_stat),
    .out_push_o (out_push),
    .out_data_o (out_data)
  );

  // Result queue: oldest word shown while not empty
  hcbp_fifo #(
    .entry_t (out_word_t)
  ) u_out_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (out_push),
    .wr_data_i  (out_data),
    .rd_i       (pop && !out_stat.empty),
    .rd_data_o  (out_word_o),
    .stat_o     (out_stat)
  );

  assign empty = out_stat.empty;

endmodule

// ===== tb/tb_huffman_code_bit_packer_top.sv =====
// Self-checking testbench for the Huffman code bit packer: table loads, encodes and flushes.
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_top;
  import hcbp_pkg::*;

  // Operation code that the block has no use for; it must produce nothing
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Longest code the packer honours: the lesser of the parameter and the code word width
  localparam int MAX_CODE_LEN = 16;
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int RANDOM_WORDS = 890;
  localparam int MAX_IDLE     = 16;

  // Tracks the code table and the pending byte, and holds the bytes still owed by the block
  class byte_packer_scoreboard;
    logic [CODE_W-1:0] code_tbl [256];
    logic [LEN_W-1:0]  len_tbl [256];
    logic [BYTE_W-1:0] pend_bits;
    logic [2:0]        pend_cnt;
    out_word_t         expected_bytes [$];
    int                errors;

    function new();
      foreach (len_tbl[k]) begin
        code_tbl[k] = '0;
        len_tbl[k]  = '0;
      end
      pend_bits = '0;
      pend_cnt  = '0;
      errors    = 0;
    endfunction

    // Update the table or the pending byte and queue any bytes the word completes
    function void predict_bytes(in_word_t w);
      out_word_t         produced [$];
      out_word_t         ob;
      logic [CODE_W-1:0] cw;
      int                cl;
      case (w.operation)
        OP_LOAD: begin
          cl = (w.code_length > LEN_CAP) ? LEN_CAP : int'(w.code_length);
          code_tbl[w.symbol] = w.code_word;
          len_tbl[w.symbol]  = LEN_W'(cl);
        end
        OP_ENCODE: begin
          cw = code_tbl[w.symbol];
          cl = len_tbl[w.symbol];
          for (int i = 0; i < cl; i++) begin
            pend_bits[LAST_BIT_POS - pend_cnt] = cw[i];
            if (pend_cnt == 3'(LAST_BIT_POS)) begin
              ob.out_byte    = pend_bits;
              ob.last_of_run = 1'b0;
              produced.push_back(ob);
              pend_bits = '0;
              pend_cnt  = '0;
            end else begin
              pend_cnt = pend_cnt + 3'd1;
            end
          end
          // Mark the final byte of this symbol
          if (produced.size() > 0) begin
            produced[produced.size() - 1].last_of_run = 1'b1;
          end
          foreach (produced[k]) expected_bytes.push_back(produced[k]);
        end
        OP_FLUSH: begin
          ob.out_byte    = pend_bits;
          ob.last_of_run = 1'b1;
          expected_bytes.push_back(ob);
          pend_bits = '0;
          pend_cnt  = '0;
        end
        default: ;
      endcase
    endfunction

    // Compare one popped byte with the oldest one owed
    function void check_byte(out_word_t got);
      out_word_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected nothing, got 0x%02h (last_of_run %0b)",
               got.out_byte, got.last_of_run);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_word;

  byte_packer_scoreboard sb = new();

  // Symbols whose table entry has been written; most encodes pick one of these
  bit       loaded [256];
  int       loaded_syms [$];
  int       send_burst = 0;
  int       pop_burst = 0;
  bit       reset_done = 1'b0;

  huffman_code_bit_packer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Draw an idle count: mostly up to MAX_IDLE, with occasional stretches of back-to-back words
  function automatic int draw_idle(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // Offer one word, hold it until the block takes it, then tell the scoreboard
  task automatic send_word(input logic [1:0] op, input int sym, input int code, input int len);
    in_word_t w;
    int       gap;
    w.operation   = op;
    w.symbol      = SYM_W'(sym);
    w.code_word   = CODE_W'(code);
    w.code_length = LEN_W'(len);
    if (op == OP_LOAD && !loaded[w.symbol]) begin
      loaded[w.symbol] = 1'b1;
      loaded_syms.push_back(int'(w.symbol));
    end
    gap = draw_idle(send_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    // Sample full as it stood just before the edge
    do @(posedge clk_i); while (full);
    sb.predict_bytes(w);
  endtask

  // Mostly loaded symbols, now and then any symbol, written or not
  task automatic encode_any();
    if ($urandom_range(0, 9) == 0)
      send_word(OP_ENCODE, $urandom_range(0, 255), 0, 0);
    else
      send_word(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)], 0, 0);
  endtask

  // Lengths: mostly legal codes, some absent entries, some beyond the cap
  function automatic int draw_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(1, 16);
    return $urandom_range(17, 31);
  endfunction

  // Result side: stall at random, then take each byte as it shows up
  initial begin : drain
    int stall;
    wait (reset_done);
    forever begin
      stall = draw_idle(pop_burst);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_byte(out_word);
    end
  end

  initial begin : stimulus
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reset_done = 1'b1;

    // Directed part: empty flush, the unused code and a never-loaded symbol first
    send_word(OP_FLUSH, 0, 0, 0);
    send_word(OP_UNUSED, 8'hFF, 16'hFFFF, 5'h1F);
    send_word(OP_ENCODE, 200, 0, 0);
    // Table extremes: full-width code, single bit, saturated lengths, absent symbol
    send_word(OP_LOAD, 0, 16'hFFFF, 16);
    send_word(OP_LOAD, 255, 16'h0000, 1);
    send_word(OP_LOAD, 128, 16'hA5C3, 31);
    send_word(OP_LOAD, 64, 16'h5A3C, 17);
    send_word(OP_LOAD, 7, 16'hFFFF, 0);
    send_word(OP_LOAD, 1, 16'h002D, 7);
    send_word(OP_LOAD, 2, 16'h0001, 8);
    // Encodes: two whole bytes, a lone bit, nothing at all, a straddling code
    send_word(OP_ENCODE, 0, 0, 0);
    send_word(OP_ENCODE, 255, 0, 0);
    send_word(OP_ENCODE, 7, 0, 0);
    send_word(OP_ENCODE, 128, 0, 0);
    send_word(OP_ENCODE, 1, 0, 0);
    send_word(OP_ENCODE, 64, 0, 0);
    send_word(OP_ENCODE, 2, 0, 0);
    send_word(OP_FLUSH, 0, 0, 0);
    // Partial byte out through a flush, then a second empty flush
    send_word(OP_ENCODE, 1, 0, 0);
    send_word(OP_FLUSH, 0, 0, 0);
    send_word(OP_FLUSH, 0, 0, 0);
    // Overwrite an entry with zero length; it must then drop out
    send_word(OP_LOAD, 0, 16'h1234, 0);
    send_word(OP_ENCODE, 0, 0, 0);
    send_word(OP_UNUSED, 8'h00, 16'h0000, 0);

    // Fill a working table before the random stream
    repeat (40) send_word(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 16'hFFFF),
                          draw_len());

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_word(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 16'hFFFF), draw_len());
      else if (r < 80)
        encode_any();
      else if (r < 94)
        send_word(OP_FLUSH, $urandom_range(0, 255), $urandom_range(0, 16'hFFFF),
                  $urandom_range(0, 31));
      else
        send_word(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 16'hFFFF),
                  $urandom_range(0, 31));
    end
    push <= 1'b0;

    // Hold until every owed byte has come, then give stray output time to show
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.outstanding() != 0)
        $error("out_byte: %0d bytes never arrived", sb.outstanding());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Drop the run if it hangs; well beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
